@@ rtl/crgb_pkg.sv @@
// Shared types, constants and the gamma curve for the clipped rectangle blit.
// No dependencies; every rtl file imports this package.
package crgb_pkg;

  localparam int unsigned EDGE_W      = 11;
  localparam int unsigned OFS_W       = 22;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned MAX_EDGE    = 1024;
  localparam int unsigned FRAME_RESET = 1024;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_RECT  = 1'b0,
    KIND_PIXEL = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [EDGE_W-1:0] width;
    logic [EDGE_W-1:0] height;
  } frame_cfg_t;

  typedef struct packed {
    item_kind_e         kind;
    logic               empty;
    logic [EDGE_W-1:0]  top;
    logic [EDGE_W-1:0]  left;
    logic [EDGE_W-1:0]  bottom;
    logic [EDGE_W-1:0]  right;
    logic [COLOR_W-1:0] color;
  } blit_item_t;

  localparam logic [7:0] GAMMA_CURVE [256] = '{
    8'h00, 8'h04, 8'h07, 8'h09, 8'h0b, 8'h0d, 8'h0f, 8'h11,
    8'h13, 8'h15, 8'h16, 8'h18, 8'h1a, 8'h1b, 8'h1d, 8'h1e,
    8'h20, 8'h21, 8'h23, 8'h24, 8'h26, 8'h27, 8'h29, 8'h2a,
    8'h2b, 8'h2d, 8'h2e, 8'h2f, 8'h31, 8'h32, 8'h33, 8'h34,
    8'h36, 8'h37, 8'h38, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
    8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h47, 8'h48,
    8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h50, 8'h51,
    8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
    8'h5a, 8'h5b, 8'h5d, 8'h5e, 8'h5f, 8'h60, 8'h61, 8'h62,
    8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a,
    8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72,
    8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a,
    8'h7b, 8'h7c, 8'h7c, 8'h7d, 8'h7e, 8'h7f, 8'h80, 8'h81,
    8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8a, 8'h8a, 8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90,
    8'h91, 8'h92, 8'h93, 8'h94, 8'h94, 8'h95, 8'h96, 8'h97,
    8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h9d, 8'h9e,
    8'h9f, 8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha4, 8'ha5,
    8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'haa, 8'hab, 8'hac,
    8'had, 8'hae, 8'haf, 8'hb0, 8'hb0, 8'hb1, 8'hb2, 8'hb3,
    8'hb4, 8'hb5, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba,
    8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'hbf, 8'hbf, 8'hc0,
    8'hc1, 8'hc2, 8'hc3, 8'hc4, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
    8'hc8, 8'hc8, 8'hc9, 8'hca, 8'hcb, 8'hcc, 8'hcd, 8'hcd,
    8'hce, 8'hcf, 8'hd0, 8'hd1, 8'hd1, 8'hd2, 8'hd3, 8'hd4,
    8'hd5, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd8, 8'hd9, 8'hda,
    8'hdb, 8'hdc, 8'hdc, 8'hdd, 8'hde, 8'hdf, 8'he0, 8'he0,
    8'he1, 8'he2, 8'he3, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7,
    8'he7, 8'he8, 8'he9, 8'hea, 8'hea, 8'heb, 8'hec, 8'hed,
    8'hee, 8'hee, 8'hef, 8'hf0, 8'hf1, 8'hf1, 8'hf2, 8'hf3,
    8'hf4, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf7, 8'hf8, 8'hf9,
    8'hfa, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfd, 8'hfe, 8'hff
  };

  // frame register limited to MAX_EDGE
  function automatic logic [EDGE_W-1:0] eff_edge(logic [EDGE_W-1:0] val);
    if (32'(val) > MAX_EDGE) begin
      return EDGE_W'(MAX_EDGE);
    end
    return val;
  endfunction

  // signed coordinate clamped to [0, hi]
  function automatic logic [EDGE_W-1:0] clamp_edge(logic [COORD_W-1:0] v,
                                                   logic [EDGE_W-1:0] hi);
    if (v[COORD_W-1]) begin
      return '0;
    end
    if (v > COORD_W'(hi)) begin
      return hi;
    end
    return v[EDGE_W-1:0];
  endfunction

endpackage

@@ rtl/clipped_rect_gamma_blit_top.sv @@
// An accepted beat is written into the queue, then into the back end's output registers.
// Throughput: one item per cycle while no stall holds the flow, using the back step's one
// 11x11 multiplier; a two-entry queue lets input and output stall independently.
// Reset: asynchronous, active low; no rectangle open, queue empty, output empty,
// frame_width and frame_height at 1024.
module clipped_rect_gamma_blit_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [15:0] rect_top_i,
  input  logic signed [15:0] rect_left_i,
  input  logic signed [15:0] rect_bottom_i,
  input  logic signed [15:0] rect_right_i,
  input  logic [31:0]        pixel_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic               empty_rect_o,
  output logic [10:0]        out_x_o,
  output logic [10:0]        out_y_o,
  output logic [10:0]        out_width_o,
  output logic [10:0]        out_height_o,
  output logic [21:0]        byte_offset_o,
  output logic [31:0]        pixel_out_o,
  output logic               last_pixel_o,
  output logic               stray_pixel_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [10:0]        cfg_data_i
);
  import crgb_pkg::*;

  logic [EDGE_W-1:0] frame_width_q, frame_height_q;
  frame_cfg_t        frame;
  blit_item_t        front_item, queue_item;
  logic              queue_full, queue_valid, queue_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= EDGE_W'(FRAME_RESET);
      frame_height_q <= EDGE_W'(FRAME_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign frame.width  = eff_edge(frame_width_q);
  assign frame.height = eff_edge(frame_height_q);
  assign in_stall_o   = queue_full;

  crgb_front u_front (
    .kind_i        (kind_i),
    .rect_top_i    (rect_top_i),
    .rect_left_i   (rect_left_i),
    .rect_bottom_i (rect_bottom_i),
    .rect_right_i  (rect_right_i),
    .pixel_in_i    (pixel_in_i),
    .frame_i       (frame),
    .item_o        (front_item)
  );

  crgb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .item_o      (queue_item)
  );

  crgb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (queue_valid),
    .item_i        (queue_item),
    .item_pop_o    (queue_pop),
    .frame_width_i (frame.width),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .empty_rect_o  (empty_rect_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_width_o   (out_width_o),
    .out_height_o  (out_height_o),
    .byte_offset_o (byte_offset_o),
    .pixel_out_o   (pixel_out_o),
    .last_pixel_o  (last_pixel_o),
    .stray_pixel_o (stray_pixel_o)
  );

endmodule

@@ rtl/crgb_front.sv @@
// Front classifier: clamps rectangle beats to the frame and gamma-corrects pixels.
// Depends on crgb_pkg; output feeds crgb_queue.
module crgb_front (
  input  logic                         kind_i,
  input  logic signed [15:0]           rect_top_i,
  input  logic signed [15:0]           rect_left_i,
  input  logic signed [15:0]           rect_bottom_i,
  input  logic signed [15:0]           rect_right_i,
  input  logic [31:0]                  pixel_in_i,
  input  crgb_pkg::frame_cfg_t         frame_i,
  output crgb_pkg::blit_item_t         item_o
);
  import crgb_pkg::*;

  logic [EDGE_W-1:0] top, left, bottom, right;

  always_comb begin
    top    = clamp_edge(COORD_W'(unsigned'(rect_top_i)), frame_i.height);
    left   = clamp_edge(COORD_W'(unsigned'(rect_left_i)), frame_i.width);
    bottom = clamp_edge(COORD_W'(unsigned'(rect_bottom_i)), frame_i.height);
    right  = clamp_edge(COORD_W'(unsigned'(rect_right_i)), frame_i.width);

    item_o.kind   = item_kind_e'(kind_i);
    item_o.empty  = (top >= bottom) || (left >= right);
    item_o.top    = top;
    item_o.left   = left;
    item_o.bottom = bottom;
    item_o.right  = right;
    // byte 0 to the top byte, byte 2 just above the zero low byte
    item_o.color  = {GAMMA_CURVE[pixel_in_i[7:0]],
                     GAMMA_CURVE[pixel_in_i[15:8]],
                     GAMMA_CURVE[pixel_in_i[23:16]]};
  end

endmodule

@@ rtl/crgb_queue.sv @@
// Short FIFO of classified items between front and back.
// Depends on crgb_pkg for the item type and depth.
module crgb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  crgb_pkg::blit_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output crgb_pkg::blit_item_t item_o
);
  import crgb_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  blit_item_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    if (32'(p) == QUEUE_DEPTH - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= QUEUE_DEPTH)
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

@@ rtl/crgb_back.sv @@
// Back end: tracks the open rectangle, walks its pixels and registers results.
// Depends on crgb_pkg; takes items from crgb_queue.
module crgb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  crgb_pkg::blit_item_t item_i,
  output logic                 item_pop_o,
  input  logic [10:0]          frame_width_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 result_kind_o,
  output logic                 empty_rect_o,
  output logic [10:0]          out_x_o,
  output logic [10:0]          out_y_o,
  output logic [10:0]          out_width_o,
  output logic [10:0]          out_height_o,
  output logic [21:0]          byte_offset_o,
  output logic [31:0]          pixel_out_o,
  output logic                 last_pixel_o,
  output logic                 stray_pixel_o
);
  import crgb_pkg::*;

  localparam int unsigned PROD_W = OFS_W - 2;

  logic                  out_valid_q;
  logic                  rect_open_q;
  logic [EDGE_W-1:0]     clip_left_q, clip_right_q, clip_bottom_q;
  logic [EDGE_W-1:0]     cur_col_q, cur_line_q;
  logic [OFS_W-1:0]      cur_offset_q;

  logic                  kind_q, empty_q, last_q, stray_q;
  logic [EDGE_W-1:0]     x_q, y_q, w_q, h_q;
  logic [OFS_W-1:0]      ofs_q;
  logic [PIX_W-1:0]      pix_q;

  logic                  load;
  logic [EDGE_W-1:0]     col_inc, line_inc, mul_line, mul_col;
  logic [2*EDGE_W-1:0]   product;
  logic [PROD_W-1:0]     row_sum;
  logic [OFS_W-1:0]      row_ofs;

  assign load       = item_valid_i && (!out_valid_q || !out_stall_i);
  assign item_pop_o = load;

  // one multiplier shared by rectangle start and row wrap
  always_comb begin
    col_inc  = cur_col_q + 1'b1;
    line_inc = cur_line_q + 1'b1;
    mul_line = (item_i.kind == KIND_RECT) ? item_i.top : line_inc;
    mul_col  = (item_i.kind == KIND_RECT) ? item_i.left : clip_left_q;
    product  = mul_line * frame_width_i;
    row_sum  = product[PROD_W-1:0] + PROD_W'(mul_col);
    row_ofs  = {row_sum, 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      rect_open_q   <= 1'b0;
      clip_left_q   <= '0;
      clip_right_q  <= '0;
      clip_bottom_q <= '0;
      cur_col_q     <= '0;
      cur_line_q    <= '0;
      cur_offset_q  <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        unique case (item_i.kind)
          KIND_RECT: begin
            rect_open_q <= !item_i.empty;
            if (!item_i.empty) begin
              clip_left_q   <= item_i.left;
              clip_right_q  <= item_i.right;
              clip_bottom_q <= item_i.bottom;
              cur_col_q     <= item_i.left;
              cur_line_q    <= item_i.top;
              cur_offset_q  <= row_ofs;
            end
          end
          KIND_PIXEL: begin
            if (rect_open_q) begin
              if (col_inc >= clip_right_q) begin
                cur_col_q    <= clip_left_q;
                cur_line_q   <= line_inc;
                cur_offset_q <= row_ofs;
                if (line_inc >= clip_bottom_q) begin
                  rect_open_q <= 1'b0;
                end
              end else begin
                cur_col_q    <= col_inc;
                cur_offset_q <= cur_offset_q + OFS_W'(4);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= item_i.kind;
      empty_q <= 1'b0;
      last_q  <= 1'b0;
      stray_q <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      w_q     <= '0;
      h_q     <= '0;
      ofs_q   <= '0;
      pix_q   <= '0;
      unique case (item_i.kind)
        KIND_RECT: begin
          if (item_i.empty) begin
            empty_q <= 1'b1;
          end else begin
            x_q   <= item_i.left;
            y_q   <= item_i.top;
            w_q   <= item_i.right - item_i.left;
            h_q   <= item_i.bottom - item_i.top;
            ofs_q <= row_ofs;
          end
        end
        KIND_PIXEL: begin
          if (!rect_open_q) begin
            stray_q <= 1'b1;
          end else begin
            ofs_q  <= cur_offset_q;
            pix_q  <= {item_i.color, 8'h00};
            last_q <= (col_inc >= clip_right_q) && (line_inc >= clip_bottom_q);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign empty_rect_o  = empty_q;
  assign out_x_o       = x_q;
  assign out_y_o       = y_q;
  assign out_width_o   = w_q;
  assign out_height_o  = h_q;
  assign byte_offset_o = ofs_q;
  assign pixel_out_o   = pix_q;
  assign last_pixel_o  = last_q;
  assign stray_pixel_o = stray_q;

  a_cursor_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_open_q |-> (cur_col_q < clip_right_q) && (cur_line_q < clip_bottom_q))
    else $error("pixel cursor outside open rectangle");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q && last_q) |-> !rect_open_q)
    else $error("rectangle still open after its last pixel");

  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !item_pop_o)
    else $error("result overwritten while stalled");

endmodule
